/* hdl/nte_pkg.sv */
// shared types and word codes for the number to english word tokens block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nte_pkg;

  localparam int unsigned NUM_W    = 31;
  localparam int unsigned WORD_W   = 5;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned CNT_W    = 5;

  localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
  localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT,
    S_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    STEP_HUND,
    STEP_HWORD,
    STEP_REST,
    STEP_UNIT,
    STEP_SCALE
  } step_e;

endpackage

`default_nettype wire

/* hdl/nte_bcd_conv.sv */
// binary to decimal digit converter, one input bit per cycle (shift and add 3)
// depends on nte_pkg
`timescale 1ns / 1ps
`default_nettype none

module nte_bcd_conv (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [nte_pkg::NUM_W-1:0] number_i,
  output logic                           done_o,
  output nte_pkg::bcd_t                  digits_o
);

  logic [nte_pkg::NUM_W-1:0] bin_q, bin_d;
  nte_pkg::bcd_t             bcd_q, bcd_d;
  logic [nte_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  nte_pkg::bcd_t             adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < nte_pkg::DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = number_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      {bcd_d, bin_d} = {adj[nte_pkg::BCD_W-2:0], bin_q, 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == nte_pkg::CNT_W'(nte_pkg::NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

/* hdl/number_to_english_word_tokens_top.sv */
// number to english word tokens: top level with token sequencer and output register
// depends on nte_pkg and nte_bcd_conv
//
// usage:
//   input channel: number_i with in_valid_i / in_stall_o. a number is taken
//   when in_valid_i is high and in_stall_o is low. in_stall_o stays high from
//   acceptance until the last word of that number sits in the output register.
//   output channel: word_o and last_o with out_valid_o / out_stall_i, one word
//   per handshake; last_o marks the final word of a number.
// timing:
//   the number is converted to ten decimal digits by a shift-and-add unit, one
//   input bit per cycle. a sequencer then walks the four three-digit groups,
//   one step per cycle unless a stalled output holds it up (at most 20 steps,
//   a zero group takes one step), holding one word back so the final one can
//   be flagged. the next number can be accepted while the final word still
//   waits in the output register.
// reset clears the sequencer, the converter control and the output valid.
// a stalled output holds its word; the sequencer waits while its held word
// cannot move on.
`timescale 1ns / 1ps
`default_nettype none

module number_to_english_word_tokens_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [nte_pkg::NUM_W-1:0]  number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [nte_pkg::WORD_W-1:0]      word_o,
  output logic                            last_o
);

  nte_pkg::state_e state_q, state_d;
  nte_pkg::step_e  step_q, step_d;
  logic [1:0]      grp_q, grp_d;
  logic            zero_q, zero_d;

  logic [nte_pkg::WORD_W-1:0] hold_q, hold_d;
  logic                       hold_vld_q, hold_vld_d;
  logic [nte_pkg::WORD_W-1:0] word_q, word_d;
  logic                       last_q, last_d;
  logic                       out_vld_q, out_vld_d;

  logic          accept;
  logic          conv_done;
  nte_pkg::bcd_t digits;
  logic [11:0]   grp;
  logic [3:0]    hd, td, ud;
  logic          grp_nz;
  logic          emit;
  logic          next_grp;
  logic          out_free;
  logic [nte_pkg::WORD_W-1:0] tok;

  assign in_stall_o = (state_q != nte_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  nte_bcd_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .number_i (number_i),
    .done_o   (conv_done),
    .digits_o (digits)
  );

  // billion group has only its units digit
  always_comb begin
    case (grp_q)
      2'd3:    grp = {8'd0, digits[39:36]};
      2'd2:    grp = digits[35:24];
      2'd1:    grp = digits[23:12];
      default: grp = digits[11:0];
    endcase
  end

  assign hd     = grp[11:8];
  assign td     = grp[7:4];
  assign ud     = grp[3:0];
  assign grp_nz = (grp != 12'd0);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    grp_d      = grp_q;
    zero_d     = zero_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    word_d     = word_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q && out_stall_i;
    emit       = 1'b0;
    next_grp   = 1'b0;
    tok        = nte_pkg::TOK_ZERO;

    case (state_q)
      nte_pkg::S_IDLE: begin
        if (accept) begin
          zero_d  = (number_i == '0);
          state_d = nte_pkg::S_CONV;
        end
      end

      nte_pkg::S_CONV: begin
        if (conv_done) begin
          if (zero_q) begin
            hold_d     = nte_pkg::TOK_ZERO;
            hold_vld_d = 1'b1;
            state_d    = nte_pkg::S_FLUSH;
          end else begin
            grp_d   = 2'd3;
            step_d  = nte_pkg::STEP_HUND;
            state_d = nte_pkg::S_EMIT;
          end
        end
      end

      nte_pkg::S_EMIT: begin
        case (step_q)
          nte_pkg::STEP_HUND: begin
            emit = grp_nz && (hd != 4'd0);
            tok  = {1'b0, hd};
          end
          nte_pkg::STEP_HWORD: begin
            emit = (hd != 4'd0);
            tok  = nte_pkg::TOK_HUNDRED;
          end
          nte_pkg::STEP_REST: begin
            if (td == 4'd0) begin
              emit = (ud != 4'd0);
              tok  = {1'b0, ud};
            end else if (td == 4'd1) begin
              emit = 1'b1;
              tok  = nte_pkg::TOK_TEN + {1'b0, ud};
            end else begin
              emit = 1'b1;
              tok  = nte_pkg::TOK_TENS_BASE + {1'b0, td};
            end
          end
          nte_pkg::STEP_UNIT: begin
            emit = (td >= 4'd2) && (ud != 4'd0);
            tok  = {1'b0, ud};
          end
          nte_pkg::STEP_SCALE: begin
            emit = (grp_q != 2'd0);
            tok  = nte_pkg::TOK_HUNDRED + {3'd0, grp_q};
          end
          default: begin
            emit = 1'b0;
          end
        endcase

        // the held word moves out only when a newer one replaces it
        if (!emit || !hold_vld_q || out_free) begin
          if (emit) begin
            if (hold_vld_q) begin
              word_d    = hold_q;
              last_d    = 1'b0;
              out_vld_d = 1'b1;
            end
            hold_d     = tok;
            hold_vld_d = 1'b1;
          end
          case (step_q)
            nte_pkg::STEP_HUND: begin
              if (grp_nz) begin
                step_d = nte_pkg::STEP_HWORD;
              end else begin
                next_grp = 1'b1;
              end
            end
            nte_pkg::STEP_HWORD: step_d = nte_pkg::STEP_REST;
            nte_pkg::STEP_REST:  step_d = nte_pkg::STEP_UNIT;
            nte_pkg::STEP_UNIT:  step_d = nte_pkg::STEP_SCALE;
            default:             next_grp = 1'b1;
          endcase
          if (next_grp) begin
            step_d = nte_pkg::STEP_HUND;
            if (grp_q == 2'd0) begin
              state_d = nte_pkg::S_FLUSH;
            end else begin
              grp_d = grp_q - 2'd1;
            end
          end
        end
      end

      nte_pkg::S_FLUSH: begin
        if (out_free) begin
          word_d     = hold_q;
          last_d     = 1'b1;
          out_vld_d  = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = nte_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = nte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nte_pkg::S_IDLE;
      step_q     <= nte_pkg::STEP_HUND;
      grp_q      <= 2'd0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      grp_q      <= grp_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    hold_q <= hold_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_vld_q;
  assign word_o      = word_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* bench/number_to_english_word_tokens_top_test.sv */
// self-checking testbench for number_to_english_word_tokens_top: a directed table,
// then random numbers shaped by decimal group, both ports idling at random
// depends on nte_pkg and the number_to_english_word_tokens_top rtl
`timescale 1ns / 1ps

module number_to_english_word_tokens_top_test;

  localparam logic [nte_pkg::WORD_W-1:0] TOK_ONE      = 5'd1;
  localparam logic [nte_pkg::WORD_W-1:0] TOK_THOUSAND = 5'd29;
  localparam logic [nte_pkg::WORD_W-1:0] TOK_MILLION  = 5'd30;
  localparam logic [nte_pkg::WORD_W-1:0] TOK_BILLION  = 5'd31;

  localparam int unsigned NUM_MAX      = 32'h7fff_ffff;
  localparam int          RANDOM_ITEMS = 236;
  localparam int          DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [nte_pkg::WORD_W-1:0] word;
    logic                       last;
  } word_tok_t;

  // n_typed == 0: expected words come from spell_number
  typedef struct packed {
    logic [nte_pkg::NUM_W-1:0]       num;
    logic [2:0]                      n_typed;
    logic [0:3][nte_pkg::WORD_W-1:0] typed;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{31'd0,          3'd1,
      {nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd10,         3'd1,
      {nte_pkg::TOK_TEN, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd100,        3'd2,
      {TOK_ONE, nte_pkg::TOK_HUNDRED, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd1000,       3'd2,
      {TOK_ONE, TOK_THOUSAND, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd1000000,    3'd2,
      {TOK_ONE, TOK_MILLION, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd1000000000, 3'd2,
      {TOK_ONE, TOK_BILLION, nte_pkg::TOK_ZERO, nte_pkg::TOK_ZERO}},
    '{31'd2147483647, 3'd0, '0},
    '{31'd1,          3'd0, '0},
    '{31'd19,         3'd0, '0},
    '{31'd20,         3'd0, '0},
    '{31'd21,         3'd0, '0},
    '{31'd90,         3'd0, '0},
    '{31'd99,         3'd0, '0},
    '{31'd101,        3'd0, '0},
    '{31'd110,        3'd0, '0},
    '{31'd115,        3'd0, '0},
    '{31'd120,        3'd0, '0},
    '{31'd999,        3'd0, '0},
    '{31'd1001,       3'd0, '0},
    '{31'd1000001,    3'd0, '0},
    '{31'd999999999,  3'd0, '0},
    '{31'd1100000000, 3'd0, '0},
    '{31'd2000000000, 3'd0, '0},
    '{31'd1234567890, 3'd0, '0}
  };

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [nte_pkg::NUM_W-1:0]  number_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [nte_pkg::WORD_W-1:0] word_o;
  logic                       last_o;

  word_tok_t pending_words [$];
  int        fail_count = 0;
  bit        calm = 1'b0;  // no new idling starts on either side while set

  number_to_english_word_tokens_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word_o),
    .last_o      (last_o)
  );

  always #4 clk_i = ~clk_i;

  // appends the english word codes of num, final one flagged
  function automatic void spell_number(input logic [nte_pkg::NUM_W-1:0] num);
    int unsigned                scale_div [4];
    logic [nte_pkg::WORD_W-1:0] scale_tok [4];
    logic [nte_pkg::WORD_W-1:0] codes [$];
    int unsigned                grp;
    int unsigned                rest;
    scale_div = '{1000000000, 1000000, 1000, 1};
    scale_tok = '{TOK_BILLION, TOK_MILLION, TOK_THOUSAND, nte_pkg::TOK_ZERO};
    for (int g = 0; g < 4; g++) begin
      grp = (int'(num) / scale_div[g]) % 1000;
      if (grp != 0) begin
        if (grp >= 100) begin
          codes.push_back(nte_pkg::WORD_W'(grp / 100));
          codes.push_back(nte_pkg::TOK_HUNDRED);
        end
        rest = grp % 100;
        if (rest >= 20) begin
          codes.push_back(nte_pkg::TOK_TENS_BASE + nte_pkg::WORD_W'(rest / 10));
          if (rest % 10 != 0) codes.push_back(nte_pkg::WORD_W'(rest % 10));
        end else if (rest != 0) begin
          codes.push_back(nte_pkg::WORD_W'(rest));
        end
        if (g < 3) codes.push_back(scale_tok[g]);
      end
    end
    if (codes.size() == 0) codes.push_back(nte_pkg::TOK_ZERO);
    foreach (codes[k]) pending_words.push_back('{codes[k], k == codes.size() - 1});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one three-digit group, biased toward values below twenty, round tens, round hundreds and empty groups
  function automatic int unsigned random_group();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 19);
      2: return $urandom_range(2, 9) * 10;
      3: return $urandom_range(1, 9) * 100;
      4: return $urandom_range(1, 9) * 100 + $urandom_range(1, 19);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic logic [nte_pkg::NUM_W-1:0] random_number();
    longint unsigned v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return nte_pkg::NUM_W'($urandom);
    if (r < 3) return nte_pkg::NUM_W'($urandom_range(0, 120));
    v = longint'($urandom_range(0, 2)) * 1000000000 + longint'(random_group()) * 1000000
      + longint'(random_group()) * 1000 + longint'(random_group());
    if (v > NUM_MAX) v -= 1000000000;
    return nte_pkg::NUM_W'(v);
  endfunction

  // holds valid across back-to-back numbers; returns at the accepting edge
  task automatic offer_number(input logic [nte_pkg::NUM_W-1:0] num, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= num;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  initial begin : stimulus
    logic [nte_pkg::NUM_W-1:0] num;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      offer_number(DIRECTED[i].num, pick_gap());
      if (DIRECTED[i].n_typed == 0) begin
        spell_number(DIRECTED[i].num);
      end else begin
        for (int k = 0; k < DIRECTED[i].n_typed; k++)
          pending_words.push_back('{DIRECTED[i].typed[k], k == DIRECTED[i].n_typed - 1});
      end
    end
    drain_words();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 60 && i < 100);
      num  = random_number();
      offer_number(num, pick_gap());
      spell_number(num);
      if (i == 150) drain_words();
    end
    calm = 1'b0;
    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // output stall: free and stalled stretches of random length
  initial begin : stall_driver
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r >= 35) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(0, 6);
        end else begin
          out_stall_i <= 1'b1;
          hold = (r < 30) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    word_tok_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: word %0d last %0b", word_o, last_o);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (word_o !== want.word) begin
          $error("word mismatch: expected %0d, got %0d", want.word, word_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* number_to_english_word_tokens_top.f */
hdl/nte_pkg.sv
hdl/nte_bcd_conv.sv
hdl/number_to_english_word_tokens_top.sv
bench/number_to_english_word_tokens_top_test.sv
